/* src/escaped_api_frame_deframer_assert.svh */
`ifndef ESCAPED_API_FRAME_DEFRAMER_ASSERT_SVH
`define ESCAPED_API_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EAFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eafd assertion failed");

// next-cycle implication, checked out of reset
`define EAFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eafd assertion failed");

`endif

/* src/eafd_pkg.sv */
package eafd_pkg;

  localparam int unsigned MAX_FRAME = 128;

  localparam logic [7:0] DELIM    = 8'h7E;
  localparam logic [7:0] ESC      = 8'h7D;
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] SUM_GOOD = 8'hFF;

  localparam logic [15:0] LEN_CAP = 16'(MAX_FRAME);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic [7:0]  frame_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } core_out_t;

endpackage

/* src/eafd_in_stage.sv */
module eafd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       q_valid,
  output logic [7:0] q_byte
);

  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte <= rx_byte;
    end
  end

endmodule

/* src/eafd_core.sv */
module eafd_core import eafd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_q,
  output core_out_t  core_out
);

  phase_t     phase, phase_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] length_high, length_high_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] bytes_received, bytes_received_next;
  logic [7:0] running_sum, running_sum_next;

  logic [7:0]  b;
  logic [15:0] len_full;
  logic [7:0]  sum_new;
  logic [7:0]  count_new;

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    length_high_next    = length_high;
    payload_length_next = payload_length;
    bytes_received_next = bytes_received;
    running_sum_next    = running_sum;
    core_out            = '0;
    b                   = escape_pending ? (rx_q ^ ESC_XOR) : rx_q;
    len_full            = {length_high, b};
    sum_new             = running_sum + b;
    count_new           = bytes_received + 8'd1;

    if (phase == PH_HUNT) begin
      if (rx_q == DELIM) begin
        phase_next          = PH_LEN_HI;
        escape_pending_next = 1'b0;
      end
    end else if (!escape_pending && rx_q == ESC) begin
      escape_pending_next = 1'b1;
    end else begin
      escape_pending_next = 1'b0;
      unique case (phase)
        PH_LEN_HI: begin
          length_high_next = b;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          payload_length_next = (len_full > LEN_CAP) ? LEN_CAP[7:0] : b;
          bytes_received_next = '0;
          running_sum_next    = '0;
          phase_next          = (payload_length_next == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          core_out.valid          = 1'b1;
          core_out.res.kind       = KIND_PAYLOAD;
          core_out.res.data_byte  = b;
          core_out.res.byte_index = bytes_received[6:0];
          running_sum_next        = sum_new;
          bytes_received_next     = count_new;
          if (count_new >= payload_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          running_sum_next          = sum_new;
          core_out.valid            = 1'b1;
          core_out.res.frame_length = payload_length;
          core_out.res.last         = 1'b1;
          if (payload_length == 8'd0) begin
            core_out.res.kind = KIND_EMPTY;
          end else if (sum_new == SUM_GOOD) begin
            core_out.res.kind = KIND_GOOD;
          end else begin
            core_out.res.kind = KIND_BAD;
          end
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next          = PH_HUNT;
          escape_pending_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      escape_pending <= 1'b0;
      length_high    <= '0;
      payload_length <= '0;
      bytes_received <= '0;
      running_sum    <= '0;
    end else if (take) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      length_high    <= length_high_next;
      payload_length <= payload_length_next;
      bytes_received <= bytes_received_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

/* src/eafd_out_stage.sv */
module eafd_out_stage import eafd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  core_out_t core_out,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   res_q
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= take && core_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && core_out.valid) begin
      res_q <= core_out.res;
    end
  end

endmodule

/* src/escaped_api_frame_deframer.sv */
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   rx_byte
// out      output     out_valid / out_ready kind, data_byte, byte_index, frame_length, last
//
// one byte per cycle sustained while the output is not stalled; a result follows its byte transfer
// latency is set by the input register and the result register around the decode step
// a stalled output holds the result; the input register still takes one more byte
// rst is synchronous and clears the frame state to hunting
module escaped_api_frame_deframer import eafd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [6:0] byte_index,
  output logic [7:0] frame_length,
  output logic       last
);

`include "escaped_api_frame_deframer_assert.svh"

  logic       q_valid;
  logic [7:0] q_byte;
  logic       free;
  logic       take;
  core_out_t  core_out;
  result_t    res_q;

  assign take = q_valid && free;

  eafd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .take     (take),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  eafd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_q     (q_byte),
    .core_out (core_out)
  );

  eafd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .core_out  (core_out),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign kind         = res_q.kind;
  assign data_byte    = res_q.data_byte;
  assign byte_index   = res_q.byte_index;
  assign frame_length = res_q.frame_length;
  assign last         = res_q.last;

  `EAFD_ASSERT_NOW(a_ready_when_free, free, in_ready)
  `EAFD_ASSERT_NOW(a_end_not_payload, out_valid && last, kind != KIND_PAYLOAD)
  `EAFD_ASSERT_NOW(a_payload_fields, out_valid && kind == KIND_PAYLOAD,
    !last && frame_length == 8'd0)
  `EAFD_ASSERT_NEXT(a_taken_result_shown, take && core_out.valid, out_valid)

endmodule

/* tb/sv/escaped_api_frame_deframer_tb.sv */
module escaped_api_frame_deframer_tb;
  import eafd_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [6:0] byte_index;
  logic [7:0] frame_length;
  logic       last;

  escaped_api_frame_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] rx_stream [$];
  result_t    deframed_q [$];
  int         src_idle_pct = 31;
  int         snk_idle_pct = 62;
  int         mismatch_count = 0;
  bit         in_took = 1'b0;

  // predictor state
  phase_t     frm_phase = PH_HUNT;
  bit         esc_armed = 1'b0;
  logic [7:0] len_hi_byte = 8'h00;
  logic [7:0] capped_len = 8'h00;
  logic [7:0] taken_count = 8'h00;
  logic [7:0] frame_sum = 8'h00;

  result_t    got_res;
  result_t    want_res;

  function automatic void deframe_byte(input logic [7:0] raw);
    logic [7:0]  b;
    logic [15:0] full_len;
    result_t     r;
    b = raw;
    if (frm_phase == PH_HUNT) begin
      if (b == DELIM) begin
        frm_phase = PH_LEN_HI;
        esc_armed = 1'b0;
      end
      return;
    end
    if (esc_armed) begin
      b = b ^ ESC_XOR;
      esc_armed = 1'b0;
    end else if (b == ESC) begin
      esc_armed = 1'b1;
      return;
    end
    case (frm_phase)
      PH_LEN_HI: begin
        len_hi_byte = b;
        frm_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        full_len = {len_hi_byte, b};
        if (full_len > LEN_CAP) full_len = LEN_CAP;
        capped_len = full_len[7:0];
        taken_count = 8'h00;
        frame_sum = 8'h00;
        frm_phase = (capped_len == 8'h00) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        r.kind = KIND_PAYLOAD;
        r.data_byte = b;
        r.byte_index = taken_count[6:0];
        r.frame_length = 8'h00;
        r.last = 1'b0;
        deframed_q.push_back(r);
        frame_sum = frame_sum + b;
        taken_count = taken_count + 8'd1;
        if (taken_count >= capped_len) frm_phase = PH_CHECK;
      end
      PH_CHECK: begin
        frame_sum = frame_sum + b;
        if (capped_len == 8'h00) r.kind = KIND_EMPTY;
        else if (frame_sum == SUM_GOOD) r.kind = KIND_GOOD;
        else r.kind = KIND_BAD;
        r.data_byte = 8'h00;
        r.byte_index = 7'h00;
        r.frame_length = capped_len;
        r.last = 1'b1;
        deframed_q.push_back(r);
        frm_phase = PH_HUNT;
      end
      default: begin
        frm_phase = PH_HUNT;
        esc_armed = 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
    if (got.data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte got %h want %h", got.data_byte, want.data_byte));
    if (got.byte_index !== want.byte_index)
      report_mismatch($sformatf("byte_index got %0d want %0d", got.byte_index,
                                want.byte_index));
    if (got.frame_length !== want.frame_length)
      report_mismatch($sformatf("frame_length got %0d want %0d", got.frame_length,
                                want.frame_length));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %b want %b", got.last, want.last));
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          rx_byte <= rx_stream.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_took = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        deframe_byte(rx_byte);
      end
      if (out_valid && out_ready) begin
        got_res.kind = kind_t'(kind);
        got_res.data_byte = data_byte;
        got_res.byte_index = byte_index;
        got_res.frame_length = frame_length;
        got_res.last = last;
        if (deframed_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want_res = deframed_q.pop_front();
          check_result(got_res, want_res);
        end
      end
    end
  end

  function automatic logic [7:0] rand_data();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return DELIM;
    if (sel < 20) return ESC;
    return 8'($urandom);
  endfunction

  task automatic push_coded(input logic [7:0] b, input int esc_pct);
    if (b == DELIM || b == ESC || $urandom_range(99) < esc_pct) begin
      rx_stream.push_back(ESC);
      rx_stream.push_back(b ^ ESC_XOR);
    end else begin
      rx_stream.push_back(b);
    end
  endtask

  task automatic queue_frame(input logic [15:0] len_field, input int sent, input bit good,
                             input int esc_pct);
    logic [7:0] d;
    logic [7:0] sum;
    logic [7:0] ck;
    sum = 8'h00;
    rx_stream.push_back(DELIM);
    push_coded(len_field[15:8], esc_pct);
    push_coded(len_field[7:0], esc_pct);
    for (int i = 0; i < sent; i++) begin
      d = rand_data();
      // a bare delimiter is plain data inside a frame
      if (d == DELIM && $urandom_range(1)) rx_stream.push_back(d);
      else push_coded(d, esc_pct);
      sum = sum + d;
    end
    ck = 8'hFF - sum;
    if (!good) ck = ck + 8'($urandom_range(1, 255));
    push_coded(ck, esc_pct);
  endtask

  task automatic queue_random(input int n_bytes);
    int sel;
    int len;
    while (rx_stream.size() < n_bytes) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        queue_frame(16'($urandom_range(MAX_FRAME + 1, 65535)), MAX_FRAME,
                    1'($urandom_range(1)), 5);
        repeat ($urandom_range(3)) rx_stream.push_back(8'($urandom_range(0, 8'h7D)));
      end else if (sel < 7) begin
        queue_frame(16'(MAX_FRAME), MAX_FRAME, 1'($urandom_range(1)), 5);
      end else if (sel < 15) begin
        repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom));
      end else if (sel < 22) begin
        rx_stream.push_back(DELIM);
        repeat ($urandom_range(6)) rx_stream.push_back(rand_data());
      end else begin
        len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 16);
        queue_frame(16'(len), len, 1'($urandom_range(1)), 15);
      end
    end
  endtask

  task automatic wait_drained();
    wait (rx_stream.size() == 0 && !in_valid);
    wait (deframed_q.size() == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // noise while hunting, escape included
    rx_stream.push_back(8'h00); rx_stream.push_back(8'hFF); rx_stream.push_back(ESC);
    // empty frame
    rx_stream.push_back(DELIM); rx_stream.push_back(8'h00); rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    // one byte, bare delimiter as data, good sum
    rx_stream.push_back(DELIM); rx_stream.push_back(8'h00); rx_stream.push_back(8'h01);
    rx_stream.push_back(DELIM); rx_stream.push_back(8'h81);
    // escape after escape, then escaped escape, bad sum
    rx_stream.push_back(DELIM); rx_stream.push_back(8'h00); rx_stream.push_back(8'h02);
    rx_stream.push_back(ESC); rx_stream.push_back(ESC);
    rx_stream.push_back(ESC); rx_stream.push_back(8'h5D);
    rx_stream.push_back(8'h00);
    // payload extremes, good sum
    rx_stream.push_back(DELIM); rx_stream.push_back(8'h00); rx_stream.push_back(8'h02);
    rx_stream.push_back(8'h00); rx_stream.push_back(8'hFF); rx_stream.push_back(8'h00);
    wait_drained();

    queue_random(300);
    wait_drained();

    src_idle_pct = 62;
    snk_idle_pct = 31;
    queue_random(300);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_random(300);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("escaped_api_frame_deframer_tb passed");
    end else begin
      $display("escaped_api_frame_deframer_tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("escaped_api_frame_deframer_tb failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/eafd_pkg.sv
src/eafd_in_stage.sv
src/eafd_core.sv
src/eafd_out_stage.sv
src/escaped_api_frame_deframer.sv
tb/sv/escaped_api_frame_deframer_tb.sv
